// File: sv/tpts_pkg.sv
// Shared types and constants of the two-axis pulse target sequencer.
// Holds the item, configuration and result structs and the code constants.
// Depends on nothing; every other file imports it.
package tpts_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int PULSE_WIDTH     = 20;
   localparam int POWER_WIDTH     = 8;
   localparam int MODE_WIDTH      = 3;
   localparam int KIND_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_LIFT_COUNT   = 2'd0,
      KIND_PULLER_COUNT = 2'd1,
      KIND_COMMAND      = 2'd2,
      KIND_TICK         = 2'd3
   } kind_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_IDLE    = 3'd0,
      MODE_RAISE   = 3'd1,
      MODE_PULL    = 3'd2,
      MODE_RELEASE = 3'd3,
      MODE_SETUP   = 3'd4
   } mode_type;

   // Command codes; the whole 32-bit value is decoded.
   localparam logic [VALUE_WIDTH-1:0] CMD_LIFT_DOWN   = 32'd1;
   localparam logic [VALUE_WIDTH-1:0] CMD_LIFT_STOP   = 32'd2;
   localparam logic [VALUE_WIDTH-1:0] CMD_PULLER_DOWN = 32'd3;
   localparam logic [VALUE_WIDTH-1:0] CMD_PULLER_STOP = 32'd4;
   localparam logic [VALUE_WIDTH-1:0] CMD_RAISE       = 32'd5;
   localparam logic [VALUE_WIDTH-1:0] CMD_PULL        = 32'd6;
   localparam logic [VALUE_WIDTH-1:0] CMD_SETUP       = 32'd7;
   localparam logic [VALUE_WIDTH-1:0] CMD_RELEASE     = 32'd8;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIFT_RAISE    = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIFT_SETUP    = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULL          = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULLER_SETUP  = 4'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIFT_DOWN_PWR = 4'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIFT_UP_PWR   = 4'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULLER_DN_PWR = 4'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULLER_UP_PWR = 4'd7;

   // Reset values of the configuration registers.
   localparam logic [PULSE_WIDTH-1:0]        RST_LIFT_RAISE    = 20'd47000;
   localparam logic [PULSE_WIDTH-1:0]        RST_LIFT_SETUP    = 20'd47000;
   localparam logic [PULSE_WIDTH-1:0]        RST_PULL          = 20'd6500;
   localparam logic [PULSE_WIDTH-1:0]        RST_PULLER_SETUP  = 20'd24500;
   localparam logic signed [POWER_WIDTH-1:0] RST_LIFT_DOWN_PWR = -8'sd100;
   localparam logic signed [POWER_WIDTH-1:0] RST_LIFT_UP_PWR   = 8'sd100;
   localparam logic signed [POWER_WIDTH-1:0] RST_PULLER_DN_PWR = -8'sd95;
   localparam logic signed [POWER_WIDTH-1:0] RST_PULLER_UP_PWR = 8'sd95;

   typedef struct packed {
      logic [PULSE_WIDTH-1:0]        lift_raise_pulses;
      logic [PULSE_WIDTH-1:0]        lift_setup_pulses;
      logic [PULSE_WIDTH-1:0]        pull_pulses;
      logic [PULSE_WIDTH-1:0]        puller_setup_pulses;
      logic signed [POWER_WIDTH-1:0] lift_down_power;
      logic signed [POWER_WIDTH-1:0] lift_up_power;
      logic signed [POWER_WIDTH-1:0] puller_down_power;
      logic signed [POWER_WIDTH-1:0] puller_up_power;
   } cfg_type;

   typedef struct packed {
      kind_type                      kind;
      logic signed [VALUE_WIDTH-1:0] value;
   } item_type;

   typedef struct packed {
      logic signed [POWER_WIDTH-1:0] lift_power;
      logic signed [POWER_WIDTH-1:0] puller_power;
      mode_type                      mode;
   } result_type;

endpackage

// File: sv/two_axis_pulse_target_sequencer.sv
// Top level of the two-axis pulse target sequencer: request register, control
// of the result hand-off, configuration port. Depends on tpts_pkg, tpts_csr, tpts_core.
//
//   channel  ports                    direction  accepted when
//   request  req_kind, req_value      in         req_valid && !req_stall
//   result   rsp_lift_power, ...mode  out        rsp_valid && !rsp_stall
//   csr      csr_index, csr_data      in         csr_valid && csr_ready
//
// Every request yields one result: it is held in the request register, then
// taken by the state update, whose registers are the result.
// One request is accepted per cycle while the result side does not stall.
// Reset is synchronous and restores counts, targets, drives, mode and registers.
// A stalled result holds the update stage, which then stalls the request side.
// The configuration port is always ready and takes one write per cycle.
module two_axis_pulse_target_sequencer
   import tpts_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [KIND_WIDTH-1:0]         req_kind,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [POWER_WIDTH-1:0] rsp_lift_power,
   output logic signed [POWER_WIDTH-1:0] rsp_puller_power,
   output logic [MODE_WIDTH-1:0]         rsp_mode,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   cfg_type    cfg;
   result_type result;

   // The held request moves into the state when the result slot is free or
   // its current contents are being taken in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // The request payload needs no reset; it is qualified by in_valid_ff.
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff.kind  <= kind_type'(req_kind);
         in_item_ff.value <= req_value;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign csr_ready = 1'b1;

   tpts_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // The state registers only change on advance, so they hold the last
   // result steady for as long as the result side stalls.
   tpts_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_lift_power   = result.lift_power;
   assign rsp_puller_power = result.puller_power;
   assign rsp_mode         = result.mode;

   // An update always presents its result in the next cycle.
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("state update without a result");

   // A result that is not taken stays, and the state behind it stays too.
   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(result)))
      else $error("stalled result was lost or changed");

   // A held request is never dropped while the result side stalls.
   a_held_request_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("held request was lost");

endmodule

// File: sv/tpts_csr.sv
// Configuration register file of the two-axis pulse target sequencer.
// Eight registers written by index; depends on tpts_pkg.
module tpts_csr
   import tpts_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] wr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;

   // Bits above a register's width are dropped; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lift_raise_pulses   <= RST_LIFT_RAISE;
         cfg_ff.lift_setup_pulses   <= RST_LIFT_SETUP;
         cfg_ff.pull_pulses         <= RST_PULL;
         cfg_ff.puller_setup_pulses <= RST_PULLER_SETUP;
         cfg_ff.lift_down_power     <= RST_LIFT_DOWN_PWR;
         cfg_ff.lift_up_power       <= RST_LIFT_UP_PWR;
         cfg_ff.puller_down_power   <= RST_PULLER_DN_PWR;
         cfg_ff.puller_up_power     <= RST_PULLER_UP_PWR;
      end else if (wr_en) begin
         unique case (wr_index)
            CSR_LIFT_RAISE:    cfg_ff.lift_raise_pulses   <= wr_data[PULSE_WIDTH-1:0];
            CSR_LIFT_SETUP:    cfg_ff.lift_setup_pulses   <= wr_data[PULSE_WIDTH-1:0];
            CSR_PULL:          cfg_ff.pull_pulses         <= wr_data[PULSE_WIDTH-1:0];
            CSR_PULLER_SETUP:  cfg_ff.puller_setup_pulses <= wr_data[PULSE_WIDTH-1:0];
            CSR_LIFT_DOWN_PWR: cfg_ff.lift_down_power     <= wr_data[POWER_WIDTH-1:0];
            CSR_LIFT_UP_PWR:   cfg_ff.lift_up_power       <= wr_data[POWER_WIDTH-1:0];
            CSR_PULLER_DN_PWR: cfg_ff.puller_down_power   <= wr_data[POWER_WIDTH-1:0];
            CSR_PULLER_UP_PWR: cfg_ff.puller_up_power     <= wr_data[POWER_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/tpts_core.sv
// Sequencer state and its update for one registered item.
// Holds counts, targets, drives and mode; depends on tpts_pkg.
module tpts_core
   import tpts_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [COUNT_WIDTH-1:0] lift_count_ff, lift_count_in;
   logic [COUNT_WIDTH-1:0] puller_count_ff, puller_count_in;
   logic [COUNT_WIDTH-1:0] lift_target_ff, lift_target_in;
   logic [COUNT_WIDTH-1:0] puller_target_ff, puller_target_in;
   logic signed [POWER_WIDTH-1:0] lift_drive_ff, lift_drive_in;
   logic signed [POWER_WIDTH-1:0] puller_drive_ff, puller_drive_in;
   mode_type mode_ff, mode_in;

   logic [COUNT_WIDTH-1:0] count_ext;
   logic [COUNT_WIDTH-1:0] raise_target, pull_target, release_target;
   logic [COUNT_WIDTH-1:0] lift_setup_target, puller_setup_target;
   logic lift_above, lift_below, puller_above, puller_below;

   // The signed value is sign-extended (or cut) to the count width.
   assign count_ext = COUNT_WIDTH'(item.value);

   assign raise_target        = lift_count_ff + COUNT_WIDTH'(cfg.lift_raise_pulses);
   assign lift_setup_target   = lift_count_ff - COUNT_WIDTH'(cfg.lift_setup_pulses);
   assign pull_target         = puller_count_ff - COUNT_WIDTH'(cfg.pull_pulses);
   assign release_target      = puller_count_ff + COUNT_WIDTH'(cfg.pull_pulses);
   assign puller_setup_target = puller_count_ff - COUNT_WIDTH'(cfg.puller_setup_pulses);

   // Strict signed comparisons of counts against targets.
   assign lift_above   = $signed(lift_target_ff) < $signed(lift_count_ff);
   assign lift_below   = $signed(lift_count_ff) < $signed(lift_target_ff);
   assign puller_above = $signed(puller_target_ff) < $signed(puller_count_ff);
   assign puller_below = $signed(puller_count_ff) < $signed(puller_target_ff);

   // Next mode.
   always_comb begin
      mode_in = mode_ff;
      if (step) begin
         unique case (item.kind)
            KIND_COMMAND: begin
               unique case (item.value)
                  CMD_RAISE:   mode_in = MODE_RAISE;
                  CMD_PULL:    mode_in = MODE_PULL;
                  CMD_SETUP:   mode_in = MODE_SETUP;
                  CMD_RELEASE: mode_in = MODE_RELEASE;
                  default:     mode_in = mode_ff;
               endcase
            end
            KIND_TICK: begin
               unique case (mode_ff)
                  MODE_RAISE:   if (lift_above) mode_in = MODE_IDLE;
                  MODE_PULL:    if (puller_below) mode_in = MODE_IDLE;
                  MODE_RELEASE: if (puller_above) mode_in = MODE_IDLE;
                  MODE_SETUP:   if (lift_below && puller_below) mode_in = MODE_IDLE;
                  default:      mode_in = mode_ff;
               endcase
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   // Next counts, targets and drives.
   always_comb begin
      lift_count_in    = lift_count_ff;
      puller_count_in  = puller_count_ff;
      lift_target_in   = lift_target_ff;
      puller_target_in = puller_target_ff;
      lift_drive_in    = lift_drive_ff;
      puller_drive_in  = puller_drive_ff;
      if (step) begin
         unique case (item.kind)
            KIND_LIFT_COUNT:   lift_count_in = count_ext;
            KIND_PULLER_COUNT: puller_count_in = count_ext;
            KIND_COMMAND: begin
               unique case (item.value)
                  CMD_LIFT_DOWN:   lift_drive_in = cfg.lift_down_power;
                  CMD_LIFT_STOP:   lift_drive_in = '0;
                  CMD_PULLER_DOWN: puller_drive_in = cfg.puller_down_power;
                  CMD_PULLER_STOP: puller_drive_in = '0;
                  CMD_RAISE: begin
                     lift_target_in = raise_target;
                     lift_drive_in  = cfg.lift_up_power;
                  end
                  CMD_PULL: begin
                     puller_target_in = pull_target;
                     puller_drive_in  = cfg.puller_down_power;
                     lift_drive_in    = '0;
                  end
                  CMD_SETUP: begin
                     lift_target_in   = lift_setup_target;
                     puller_target_in = puller_setup_target;
                     lift_drive_in    = cfg.lift_down_power;
                     puller_drive_in  = cfg.puller_down_power;
                  end
                  CMD_RELEASE: begin
                     puller_target_in = release_target;
                     puller_drive_in  = cfg.puller_up_power;
                     lift_drive_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
            KIND_TICK: begin
               case (mode_ff)
                  MODE_RAISE: begin
                     if (lift_above) lift_drive_in = '0;
                  end
                  MODE_PULL: begin
                     if (puller_below) begin
                        lift_drive_in   = '0;
                        puller_drive_in = '0;
                     end
                  end
                  MODE_RELEASE: begin
                     if (puller_above) begin
                        lift_drive_in   = '0;
                        puller_drive_in = '0;
                     end
                  end
                  MODE_SETUP: begin
                     if (lift_below) lift_drive_in = '0;
                     if (puller_below) puller_drive_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_count_ff    <= '0;
         puller_count_ff  <= '0;
         lift_target_ff   <= '0;
         puller_target_ff <= '0;
         lift_drive_ff    <= '0;
         puller_drive_ff  <= '0;
         mode_ff          <= MODE_IDLE;
      end else begin
         lift_count_ff    <= lift_count_in;
         puller_count_ff  <= puller_count_in;
         lift_target_ff   <= lift_target_in;
         puller_target_ff <= puller_target_in;
         lift_drive_ff    <= lift_drive_in;
         puller_drive_ff  <= puller_drive_in;
         mode_ff          <= mode_in;
      end
   end

   assign result.lift_power   = lift_drive_ff;
   assign result.puller_power = puller_drive_ff;
   assign result.mode         = mode_ff;

   // A tick while idle changes neither drive nor mode.
   a_idle_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      (step && item.kind == KIND_TICK && mode_ff == MODE_IDLE) |=>
      ($stable(lift_drive_ff) && $stable(puller_drive_ff) && mode_ff == MODE_IDLE))
      else $error("tick in idle changed the sequencer state");

   // Only a tick can bring an active mode back to idle.
   a_idle_only_by_tick: assert property (@(posedge clock) disable iff (reset)
      (step && item.kind != KIND_TICK && mode_ff != MODE_IDLE) |=> mode_ff != MODE_IDLE)
      else $error("mode returned to idle without a tick");

   // Targets move only on a command.
   a_targets_by_command: assert property (@(posedge clock) disable iff (reset)
      !(step && item.kind == KIND_COMMAND) |=>
      ($stable(lift_target_ff) && $stable(puller_target_ff)))
      else $error("target changed without a command");

endmodule
